>>> design/strs_pkg.sv
package strs_pkg;

	localparam int MAX_ELEMENTS = 256;
	localparam int NODE_DEPTH   = 4 * MAX_ELEMENTS;
	localparam int ADDR_W       = $clog2(NODE_DEPTH);
	localparam int POS_W        = 8;
	localparam int CNT_W        = 9;
	localparam int DATA_W       = 32;
	localparam int STACK_DEPTH  = 16;
	localparam int STK_IDX_W    = $clog2(STACK_DEPTH);
	localparam int SP_W         = STK_IDX_W + 1;

	typedef enum logic [0:0] {
		OP_SET   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DESC,
		ST_UP,
		ST_QUERY,
		ST_QFIN
	} state_t;

	// One pending subtree of a range query.
	typedef struct packed {
		logic [ADDR_W-1:0] node;
		logic [POS_W-1:0]  lo;
		logic [POS_W-1:0]  hi;
	} frame_t;

endpackage

>>> design/strs_ifs.sv
interface strs_req_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [strs_pkg::POS_W-1:0]          position;
	logic signed [strs_pkg::DATA_W-1:0]  new_value;
	logic [strs_pkg::POS_W-1:0]          range_low;
	logic [strs_pkg::POS_W-1:0]          range_high;

	modport source (output valid, output op, output position, output new_value,
		output range_low, output range_high, input ready);
	modport sink (input valid, input op, input position, input new_value,
		input range_low, input range_high, output ready);
endinterface

interface strs_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [strs_pkg::DATA_W-1:0]  range_sum;
	logic                                range_ok;

	modport source (output valid, output range_sum, output range_ok, input ready);
	modport sink (input valid, input range_sum, input range_ok, output ready);
endinterface

interface strs_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [strs_pkg::CNT_W-1:0]          active_count;

	modport source (output valid, output active_count, input ready);
	modport sink (input valid, input active_count, output ready);
endinterface

>>> design/strs_ram.sv
module strs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/segment_tree_range_sum_core.sv
// Channel  Role  Handshake      Payload
// req      sink  valid / ready  op, position, new_value, range_low, range_high
// rsp      src   valid / ready  range_sum, range_ok (one item per query, none per set)
// cfg      sink  valid / ready  active_count (ready is always high)
//
// After reset a clearing pass writes zero to all 1024 node entries;
// req is not ready meanwhile, while cfg writes are taken throughout.
// A set steps down one tree level at a time to its leaf (the tree height is at most 8),
// then does one RAM read and one write per level back up to the root.
// A query visits one node at a time from a stack (at most about four per level).
// Both paces come from the single read port of the node RAM and the one shared adder.
// req is ready only between items; a finished result waits in the rsp register.
module segment_tree_range_sum_core (
	input  logic      clk,
	input  logic      arst_n,
	strs_req_if.sink  req,
	strs_rsp_if.source rsp,
	strs_cfg_if.sink  cfg
);

	strs_pkg::state_t state_q, state_nxt;

	logic [strs_pkg::CNT_W-1:0]  active_count_q;
	logic [strs_pkg::CNT_W-1:0]  n_eff;
	logic [strs_pkg::POS_W-1:0]  root_hi;
	logic                        range_valid;
	logic                        set_valid;

	logic [strs_pkg::ADDR_W-1:0] clr_q;
	logic [strs_pkg::ADDR_W-1:0] node_q;
	logic [strs_pkg::POS_W-1:0]  lo_q, hi_q, pos_q, ql_q, qh_q;
	logic [strs_pkg::DATA_W-1:0] val_q, acc_q;
	logic                        ok_q, pend_q;

	strs_pkg::frame_t            stack_q [strs_pkg::STACK_DEPTH];
	logic [strs_pkg::SP_W-1:0]   sp_q;
	logic [strs_pkg::STK_IDX_W-1:0] top_idx, nxt_idx;
	strs_pkg::frame_t            top_f, left_f, right_f, root_f;

	logic [strs_pkg::POS_W-1:0]  w_lo, w_hi, mid;
	logic [strs_pkg::ADDR_W-1:0] w_node, left_node, parent;
	logic                        leaf, disjoint, covered;
	logic [strs_pkg::DATA_W-1:0] sum;

	logic                        ram_we, ram_re;
	logic [strs_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [strs_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

	logic req_take, stk_init, stk_pop, stk_split, load_out;
	logic out_valid_q, out_ok_q;
	logic [strs_pkg::DATA_W-1:0] out_sum_q;

	// Configuration.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= '0;
		end else if (cfg.valid) begin
			active_count_q <= cfg.active_count;
		end
	end

	assign n_eff = (active_count_q > strs_pkg::CNT_W'(strs_pkg::MAX_ELEMENTS)) ?
		strs_pkg::CNT_W'(strs_pkg::MAX_ELEMENTS) : active_count_q;
	assign root_hi = strs_pkg::POS_W'(n_eff - strs_pkg::CNT_W'(1));
	assign set_valid = {1'b0, req.position} < n_eff;
	assign range_valid = (n_eff != '0) && (req.range_low <= req.range_high) &&
		({1'b0, req.range_high} < n_eff);

	// Datapath: the split point, the query tests and the shared adder.
	assign top_idx = strs_pkg::STK_IDX_W'(sp_q - strs_pkg::SP_W'(1));
	assign nxt_idx = top_idx + strs_pkg::STK_IDX_W'(1);
	assign top_f = stack_q[top_idx];

	always_comb begin
		if (state_q == strs_pkg::ST_QUERY) begin
			w_lo   = top_f.lo;
			w_hi   = top_f.hi;
			w_node = top_f.node;
		end else begin
			w_lo   = lo_q;
			w_hi   = hi_q;
			w_node = node_q;
		end
		mid       = w_lo + ((w_hi - w_lo) >> 1);
		left_node = w_node << 1;
		leaf      = (w_lo == w_hi);
		disjoint  = (qh_q < w_lo) || (w_hi < ql_q);
		covered   = (ql_q <= w_lo) && (w_hi <= qh_q);
		left_f    = '{node: left_node, lo: w_lo, hi: mid};
		right_f   = '{node: left_node | strs_pkg::ADDR_W'(1), lo: mid + strs_pkg::POS_W'(1),
			hi: w_hi};
		root_f    = '{node: strs_pkg::ADDR_W'(1), lo: '0, hi: root_hi};
		parent    = node_q >> 1;
		sum       = acc_q + ram_rdata;
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			strs_pkg::ST_CLEAR: begin
				if (clr_q == strs_pkg::ADDR_W'(strs_pkg::NODE_DEPTH - 1)) begin
					state_nxt = strs_pkg::ST_IDLE;
				end
			end
			strs_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (req.op == strs_pkg::OP_QUERY) begin
						state_nxt = range_valid ? strs_pkg::ST_QUERY : strs_pkg::ST_QFIN;
					end else if (set_valid) begin
						state_nxt = strs_pkg::ST_DESC;
					end
				end
			end
			strs_pkg::ST_DESC: begin
				if (leaf) begin
					state_nxt = (node_q == strs_pkg::ADDR_W'(1)) ?
						strs_pkg::ST_IDLE : strs_pkg::ST_UP;
				end
			end
			strs_pkg::ST_UP: begin
				if (parent == strs_pkg::ADDR_W'(1)) begin
					state_nxt = strs_pkg::ST_IDLE;
				end
			end
			strs_pkg::ST_QUERY: begin
				if (sp_q == '0) begin
					state_nxt = strs_pkg::ST_QFIN;
				end
			end
			strs_pkg::ST_QFIN: begin
				if (!out_valid_q || rsp.ready) begin
					state_nxt = strs_pkg::ST_IDLE;
				end
			end
			default: state_nxt = strs_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req.ready = 1'b0;
		req_take  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		stk_init  = 1'b0;
		stk_pop   = 1'b0;
		stk_split = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			strs_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			strs_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				req_take  = req.valid;
				stk_init  = req.valid && (req.op == strs_pkg::OP_QUERY) && range_valid;
			end
			strs_pkg::ST_DESC: begin
				if (leaf) begin
					ram_we    = 1'b1;
					ram_waddr = node_q;
					ram_wdata = val_q;
					if (node_q != strs_pkg::ADDR_W'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = node_q ^ strs_pkg::ADDR_W'(1);
					end
				end
			end
			strs_pkg::ST_UP: begin
				// The sibling read last cycle is on rdata; the parent takes the sum.
				ram_we    = 1'b1;
				ram_waddr = parent;
				ram_wdata = sum;
				if (parent != strs_pkg::ADDR_W'(1)) begin
					ram_re    = 1'b1;
					ram_raddr = parent ^ strs_pkg::ADDR_W'(1);
				end
			end
			strs_pkg::ST_QUERY: begin
				if (sp_q != '0) begin
					if (disjoint) begin
						stk_pop = 1'b1;
					end else if (covered) begin
						stk_pop   = 1'b1;
						ram_re    = 1'b1;
						ram_raddr = top_f.node;
					end else begin
						stk_split = 1'b1;
					end
				end
			end
			strs_pkg::ST_QFIN: begin
				load_out = !out_valid_q || rsp.ready;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= strs_pkg::ST_CLEAR;
			clr_q       <= '0;
			sp_q        <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			pend_q  <= ram_re;
			if (state_q == strs_pkg::ST_CLEAR) begin
				clr_q <= clr_q + strs_pkg::ADDR_W'(1);
			end
			if (stk_init) begin
				sp_q <= strs_pkg::SP_W'(1);
			end else if (stk_split) begin
				sp_q <= sp_q + strs_pkg::SP_W'(1);
			end else if (stk_pop) begin
				sp_q <= sp_q - strs_pkg::SP_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_take) begin
			node_q <= strs_pkg::ADDR_W'(1);
			lo_q   <= '0;
			hi_q   <= root_hi;
			pos_q  <= req.position;
			val_q  <= req.new_value;
			ql_q   <= req.range_low;
			qh_q   <= req.range_high;
			acc_q  <= '0;
			ok_q   <= range_valid;
		end else begin
			if (state_q == strs_pkg::ST_DESC) begin
				if (leaf) begin
					acc_q <= val_q;
				end else if (pos_q <= mid) begin
					node_q <= left_f.node;
					hi_q   <= mid;
				end else begin
					node_q <= right_f.node;
					lo_q   <= right_f.lo;
				end
			end else begin
				if (pend_q) begin
					acc_q <= sum;
				end
				if (state_q == strs_pkg::ST_UP) begin
					node_q <= parent;
				end
			end
		end
		if (stk_init) begin
			stack_q[0] <= root_f;
		end else if (stk_split) begin
			// Left child on top so that it is taken next.
			stack_q[top_idx] <= right_f;
			stack_q[nxt_idx] <= left_f;
		end
		if (load_out) begin
			out_sum_q <= acc_q;
			out_ok_q  <= ok_q;
		end
	end

	strs_ram #(
		.WIDTH(strs_pkg::DATA_W),
		.DEPTH(strs_pkg::NODE_DEPTH)
	) u_node_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rsp.valid     = out_valid_q;
	assign rsp.range_sum = out_sum_q;
	assign rsp.range_ok  = out_ok_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= strs_pkg::SP_W'(strs_pkg::STACK_DEPTH))
		else $error("query stack overflow");

	a_up_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == strs_pkg::ST_UP |-> pend_q)
		else $error("ascent step without sibling read");

	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == strs_pkg::ST_QFIN |-> !pend_q)
		else $error("result taken before last read was added");

	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == strs_pkg::ST_QUERY |-> !ram_we)
		else $error("node store written during a query");

	a_bad_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && !ok_q |-> acc_q == '0)
		else $error("invalid range with nonzero sum");

endmodule
